FILE: sv/sir_pkg.sv
// Shared types, codes and constants of the serial image upload receiver.
package sir_pkg;

    // Start sequence length; the sequence itself lives in the control core.
    localparam int START_SEQ_LEN = 8;

    // Default page size in bytes.
    localparam int PAGE_BYTES_DEF = 256;

    // Configuration register widths, index width and reset values.
    localparam int MAX_SIZE_W = 25;
    localparam int APP_BASE_W = 24;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 1;
    localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RST = 25'h0FF_0000;
    localparam logic [APP_BASE_W-1:0] APP_BASE_RST = 24'h01_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FILE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_BASE      = 1'b1;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 4;

    // Input action codes; the fourth code is ignored.
    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_CANCEL  = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    // Protocol phase.
    typedef enum logic [1:0] {
        PH_SEQ  = 2'd0,
        PH_CRC  = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // Result event codes.
    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_START_ACK = 4'd1,
        EV_BAD_SEQ   = 4'd2,
        EV_CRC_ACK   = 4'd3,
        EV_SIZE_ACK  = 4'd4,
        EV_STAGED    = 4'd5,
        EV_DONE_OK   = 4'd6,
        EV_TOO_LARGE = 4'd7,
        EV_CRC_BAD   = 4'd8,
        EV_CANCELLED = 4'd9,
        EV_TIMEOUT   = 4'd10
    } event_t;

    // One input item.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } in_item_t;

    // One result item.
    typedef struct packed {
        event_t      ev;
        logic [7:0]  stage_byte;
        logic [7:0]  stage_offset;
        logic        program_page;
        logic [23:0] page_address;
        logic [31:0] echo_value;
    } out_item_t;

endpackage

FILE: sv/sir_in_reg.sv
// Input register stage of the upload receiver.
module sir_in_reg
    import sir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 adv,
    output logic                 in_valid,
    output in_item_t             in_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Slot is free when empty or when its item moves on this cycle
    assign s_tready   = !valid_reg || adv;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action  <= s_tuser;
            item_reg.rx_byte <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

FILE: sv/sir_core.sv
// Upload protocol state, CRC and page bookkeeping of the upload receiver.
module sir_core
    import sir_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  adv,
    input  in_item_t              in_item,
    output out_item_t             res
);

    localparam int PO_W = $clog2(PAGE_BYTES);
    localparam logic [PO_W-1:0] PO_LAST = PO_W'(PAGE_BYTES - 1);
    localparam logic [7:0] START_SEQ [16] = '{
        8'd7, 8'd3, 8'd9, 8'd3, 8'd9, 8'd1, 8'd7, 8'd3,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // Reflected CRC-32 update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        end
        return c;
    endfunction

    logic [MAX_SIZE_W-1:0] max_size_reg;
    logic [APP_BASE_W-1:0] app_base_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_index_reg, byte_index_next;
    logic [31:0] expected_crc_reg, expected_crc_next;
    logic [31:0] image_length_reg, image_length_next;
    logic [23:0] write_offset_reg, write_offset_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [PO_W-1:0] page_off_reg, page_off_next;

    logic [4:0]      sh;
    logic [31:0]     field_upd_crc;
    logic [31:0]     field_upd_len;
    logic [31:0]     bi_inc;
    logic [31:0]     crc_new;
    logic [31:0]     crc_final;
    logic [PO_W-1:0] po_inc;
    logic            last_byte;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= MAX_SIZE_RST;
            app_base_reg <= APP_BASE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAX_FILE_SIZE: max_size_reg <= cfg_wdata[MAX_SIZE_W-1:0];
                CFG_APP_BASE:      app_base_reg <= cfg_wdata[APP_BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Helper terms
    always_comb begin
        sh            = {byte_index_reg[1:0], 3'b000};
        field_upd_crc = (expected_crc_reg & ~(32'hFF << sh)) | ({24'd0, in_item.rx_byte} << sh);
        field_upd_len = (image_length_reg & ~(32'hFF << sh)) | ({24'd0, in_item.rx_byte} << sh);
        bi_inc        = byte_index_reg + 32'd1;
        crc_new       = crc_byte(running_crc_reg, in_item.rx_byte);
        crc_final     = ~crc_new;
        last_byte     = (bi_inc == image_length_reg);
        // Page offset follows byte_index modulo the page size, including the 2^32 wrap
        if (bi_inc == 32'd0 || page_off_reg == PO_LAST) begin
            po_inc = '0;
        end else begin
            po_inc = page_off_reg + PO_W'(1);
        end
    end

    // Next state and result
    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        expected_crc_next = expected_crc_reg;
        image_length_next = image_length_reg;
        write_offset_next = write_offset_reg;
        running_crc_next  = running_crc_reg;
        page_off_next     = page_off_reg;
        res               = '0;
        res.ev            = EV_NONE;

        unique case (action_t'(in_item.action))
            ACT_CANCEL, ACT_TIMEOUT: begin
                res.ev = (action_t'(in_item.action) == ACT_CANCEL) ? EV_CANCELLED : EV_TIMEOUT;
                phase_next        = PH_SEQ;
                byte_index_next   = '0;
                expected_crc_next = '0;
                image_length_next = '0;
                write_offset_next = '0;
                running_crc_next  = '1;
                page_off_next     = '0;
            end
            ACT_BYTE: begin
                unique case (phase_reg)
                    PH_SEQ: begin
                        if (byte_index_reg < 32'(START_SEQ_LEN) &&
                            in_item.rx_byte == START_SEQ[byte_index_reg[3:0]]) begin
                            if (bi_inc == 32'(START_SEQ_LEN)) begin
                                res.ev            = EV_START_ACK;
                                phase_next        = PH_CRC;
                                byte_index_next   = '0;
                                expected_crc_next = '0;
                                image_length_next = '0;
                                write_offset_next = '0;
                                running_crc_next  = '1;
                                page_off_next     = '0;
                            end else begin
                                byte_index_next = bi_inc;
                            end
                        end else begin
                            // mismatching byte is not rechecked
                            res.ev          = EV_BAD_SEQ;
                            byte_index_next = '0;
                        end
                    end
                    PH_CRC: begin
                        expected_crc_next = field_upd_crc;
                        byte_index_next   = bi_inc;
                        if (byte_index_reg[1:0] == 2'd3) begin
                            res.ev          = EV_CRC_ACK;
                            res.echo_value  = field_upd_crc;
                            phase_next      = PH_LEN;
                            byte_index_next = '0;
                        end
                    end
                    PH_LEN: begin
                        image_length_next = field_upd_len;
                        byte_index_next   = bi_inc;
                        if (byte_index_reg[1:0] == 2'd3) begin
                            res.echo_value = field_upd_len;
                            if (field_upd_len > {7'd0, max_size_reg}) begin
                                res.ev            = EV_TOO_LARGE;
                                phase_next        = PH_SEQ;
                                byte_index_next   = '0;
                                expected_crc_next = '0;
                                image_length_next = '0;
                                write_offset_next = '0;
                                running_crc_next  = '1;
                                page_off_next     = '0;
                            end else begin
                                res.ev            = EV_SIZE_ACK;
                                phase_next        = PH_DATA;
                                byte_index_next   = '0;
                                write_offset_next = app_base_reg;
                                running_crc_next  = '1;
                                page_off_next     = '0;
                            end
                        end
                    end
                    PH_DATA: begin
                        res.ev           = EV_STAGED;
                        res.stage_byte   = in_item.rx_byte;
                        res.stage_offset = 8'(page_off_reg);
                        byte_index_next  = bi_inc;
                        running_crc_next = crc_new;
                        page_off_next    = po_inc;
                        // page end or final byte: program the page
                        if (po_inc == '0 || last_byte) begin
                            res.program_page  = 1'b1;
                            res.page_address  = write_offset_reg;
                            write_offset_next = write_offset_reg + 24'(PAGE_BYTES);
                        end
                        if (last_byte) begin
                            if (crc_final != expected_crc_reg) begin
                                res.ev         = EV_CRC_BAD;
                                res.echo_value = crc_final;
                            end else begin
                                res.ev         = EV_DONE_OK;
                                res.echo_value = image_length_reg;
                            end
                            phase_next        = PH_SEQ;
                            byte_index_next   = '0;
                            expected_crc_next = '0;
                            image_length_next = '0;
                            write_offset_next = '0;
                            running_crc_next  = '1;
                            page_off_next     = '0;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    // State registers, updated when an item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SEQ;
            byte_index_reg   <= '0;
            expected_crc_reg <= '0;
            image_length_reg <= '0;
            write_offset_reg <= '0;
            running_crc_reg  <= '1;
            page_off_reg     <= '0;
        end else if (adv) begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            expected_crc_reg <= expected_crc_next;
            image_length_reg <= image_length_next;
            write_offset_reg <= write_offset_next;
            running_crc_reg  <= running_crc_next;
            page_off_reg     <= page_off_next;
        end
    end

`ifndef SYNTH
    a_prog_event: assert property (@(posedge aclk) disable iff (!aresetn)
        res.program_page |->
            (res.ev == EV_STAGED || res.ev == EV_DONE_OK || res.ev == EV_CRC_BAD))
        else $error("page program without a data byte event");

    a_page_off_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_DATA |-> page_off_reg == '0)
        else $error("page offset not cleared outside data phase");

    a_seq_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SEQ |-> byte_index_reg < 32'(START_SEQ_LEN))
        else $error("start sequence index out of range");

    a_start_to_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res.ev == EV_START_ACK) |=> (phase_reg == PH_CRC && byte_index_reg == '0))
        else $error("start ack did not enter crc phase");
`endif

endmodule

FILE: sv/sir_out_reg.sv
// Result register stage of the upload receiver.
module sir_out_reg
    import sir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  out_item_t            res,
    output logic                 adv,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t res_reg;

    // Item moves on when the result slot is empty or being drained
    assign adv        = in_valid && (!valid_reg || m_tready);
    assign valid_next = adv || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.ev;
    assign m_tdata  = {7'd0, res_reg.echo_value, res_reg.page_address,
                       res_reg.program_page, res_reg.stage_offset, res_reg.stage_byte};

endmodule

FILE: sv/serial_image_upload_receiver_top.sv
// Serial image upload receiver: one stream event in, one result transfer out per event,
// sustaining one transfer per clock while m_tready stays high; a result is presented on
// the m_ side once its event has passed the input register and then one pass through the
// protocol state update into the result register, and can be taken at the next edge; the
// state update, one combinational pass per event, sets that rate. A waiting result lets
// the input register take one more transfer; once both registers hold an event, s_tready
// follows m_tready until the result is taken. Configuration writes take effect at once
// and belong to idle periods. There is no post-reset clearing pass.
module serial_image_upload_receiver_top
    import sir_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input events
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] action
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] stage_byte, [15:8] stage_offset,
                                             // [16] program_page, [40:17] page_address,
                                             // [72:41] echo_value, [79:73] zero
    output logic [M_TUSER_W-1:0]  m_tuser    // [3:0] event_res
);

    logic      adv;
    logic      in_valid;
    in_item_t  in_item;
    out_item_t res;

    sir_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .adv      (adv),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    sir_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .adv       (adv),
        .in_item   (in_item),
        .res       (res)
    );

    sir_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .res      (res),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
